// ===== sv/sopr_pkg.sv =====
// shared types and constants of the sphere overlap push-out resolver
package sopr_pkg;

   localparam int MAX_OBJECTS = 32;
   localparam int IDX_W = $clog2(MAX_OBJECTS);
   localparam int CNT_W = IDX_W + 1;
   localparam int PASS_W = 11;
   localparam logic [PASS_W-1:0] MAX_PASSES_RESET = 11'd1000;

   // one stored object: planned centre, radius and priority
   typedef struct packed {
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] pos_z;
      logic [30:0] radius;
      logic [2:0]  prio;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

// ===== sv/sopr_ram.sv =====
// generic single write, single read ram with registered read data
module sopr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/sphere_overlap_pushout_resolver_core.sv =====
// top level of the sphere overlap push-out resolver
//
// usage:
// - req channel loads one object word per cycle: planned centre = pos + vel,
//   saturated, plus radius and priority; up to 32 objects, extras are dropped
// - the word with req_last_object set starts resolution; req_stall stays high
//   until every object has been reported
// - resolution scans ordered pairs (i outer, j inner) through the store read
//   port and the shared 32x32 multiplier: a pair with i = j is skipped, a
//   pair ruled out per axis is dropped, else the squared distance is compared
// - a fix adds a square root plus, per axis, a multiply and a restoring
//   divide, then the scan restarts from pair (0,0)
// - one word per loaded object then leaves on the rsp channel, in load
//   order; a stalled word holds
// - csr write sets max_passes; write it only while the block is idle
// - reset (synchronous, active high) empties the store, clears the hit flags
//   and sets max_passes to 1000; the store needs no clearing pass
module sphere_overlap_pushout_resolver_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [31:0] req_vel_x,
   input  logic signed [31:0] req_vel_y,
   input  logic signed [31:0] req_vel_z,
   input  logic [30:0]        req_radius,
   input  logic [2:0]         req_priority_req,
   input  logic               req_last_object,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [4:0]         rsp_object_index,
   output logic signed [31:0] rsp_final_x,
   output logic signed [31:0] rsp_final_y,
   output logic signed [31:0] rsp_final_z,
   output logic               rsp_collided,
   output logic [4:0]         rsp_partner_index,
   output logic               rsp_limit_reached,
   output logic               rsp_last_result,
   input  logic               csr_write_enable,
   input  logic [10:0]        csr_write_data
);

   typedef enum logic [15:0] {
      S_IDLE  = 16'h0001,
      S_PAIR  = 16'h0002,
      S_RDI   = 16'h0004,
      S_RDJ   = 16'h0008,
      S_CAPJ  = 16'h0010,
      S_OVL   = 16'h0020,
      S_SQ    = 16'h0040,
      S_CMP   = 16'h0080,
      S_SQRT  = 16'h0100,
      S_PMUL  = 16'h0200,
      S_DIV   = 16'h0400,
      S_APPLY = 16'h0800,
      S_WR    = 16'h1000,
      S_ORD   = 16'h2000,
      S_OLD   = 16'h4000,
      S_OSEND = 16'h8000
   } state_type;

   localparam int IW = sopr_pkg::IDX_W;
   localparam int CW = sopr_pkg::CNT_W;

   // saturate a 34-bit signed sum to 32 bits
   function automatic logic [31:0] sat34(input logic [33:0] v);
      logic [31:0] r;
      if (v[33:31] == 3'b000 || v[33:31] == 3'b111) r = v[31:0];
      else if (v[33]) r = 32'h8000_0000;
      else r = 32'h7FFF_FFFF;
      return r;
   endfunction

   state_type state_ff, state_in;

   logic [CW-1:0]    count_ff, count_in;
   logic [IW-1:0]    i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [10:0]      pass_ff, pass_in, max_passes_ff;
   logic             limit_ff, limit_in;
   logic [sopr_pkg::MAX_OBJECTS-1:0] hit_ff, hit_in;
   logic [IW-1:0]    partner_ff [sopr_pkg::MAX_OBJECTS];

   sopr_pkg::entry_type a_ff, a_in, b_ff, b_in, rd_entry, wr_entry;
   logic             wr_en;
   logic [IW-1:0]    wr_addr, rd_addr;

   // pair arithmetic
   logic [31:0]      mag_ff [3];
   logic [31:0]      mag_in [3];
   logic [2:0]       neg_ff, neg_in;
   logic [31:0]      s_ff, s_in, gap_ff, gap_in;
   logic [2:0]       sq_cnt_ff, sq_cnt_in;
   logic [63:0]      prod_ff, prod_in, s2_ff, s2_in;
   logic [65:0]      acc_ff, acc_in;
   logic [31:0]      mul_a, mul_b;
   logic [63:0]      mul_p;

   // push-out
   logic [IW-1:0]    st_idx_ff, st_idx_in, mv_idx_ff, mv_idx_in;
   logic [31:0]      st_pos_ff [3];
   logic [31:0]      st_pos_in [3];
   logic [31:0]      new_ff [3];
   logic [31:0]      new_in [3];
   logic [30:0]      mv_rad_ff, mv_rad_in;
   logic [2:0]       mv_pri_ff, mv_pri_in;
   logic [63:0]      rad_ff, rad_in;
   logic [34:0]      rem_ff, rem_in;
   logic [31:0]      root_ff, root_in, drem_ff, drem_in;
   logic [5:0]       iter_ff, iter_in;
   logic [1:0]       comp_ff, comp_in;

   // output word
   logic [4:0]       o_idx_ff, o_idx_in, o_par_ff, o_par_in;
   logic [31:0]      o_x_ff, o_x_in, o_y_ff, o_y_in, o_z_ff, o_z_in;
   logic             o_hit_ff, o_hit_in, o_last_ff, o_last_in;

   // scan advance
   logic [IW-1:0]    adv_i, adv_j;
   logic             adv_done;

   // pair differences b - a
   logic [32:0]      d_c [3];
   logic [32:0]      m_c [3];
   logic [31:0]      s_c;
   logic             no_ovl;

   // sqrt and divide steps
   logic [34:0]      rt_rem, rt_trial;
   logic [32:0]      dv_t;
   logic [33:0]      ap_off, ap_sum;

   logic             req_acc;

   assign req_acc = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OSEND);

   sopr_ram #(
      .WIDTH (sopr_pkg::ENTRY_W),
      .DEPTH (sopr_pkg::MAX_OBJECTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   // next pair in scan order
   always_comb begin
      adv_i = i_ff;
      adv_j = j_ff + 1'b1;
      adv_done = 1'b0;
      if ({1'b0, j_ff} == count_ff - 1'b1) begin
         adv_j = '0;
         if ({1'b0, i_ff} == count_ff - 1'b1) adv_done = 1'b1;
         else adv_i = i_ff + 1'b1;
      end
   end

   always_comb begin
      d_c[0] = {b_ff.pos_x[31], b_ff.pos_x} - {a_ff.pos_x[31], a_ff.pos_x};
      d_c[1] = {b_ff.pos_y[31], b_ff.pos_y} - {a_ff.pos_y[31], a_ff.pos_y};
      d_c[2] = {b_ff.pos_z[31], b_ff.pos_z} - {a_ff.pos_z[31], a_ff.pos_z};
      for (int c = 0; c < 3; c++) begin
         m_c[c] = d_c[c][32] ? (33'd0 - d_c[c]) : d_c[c];
      end
      s_c = {1'b0, a_ff.radius} + {1'b0, b_ff.radius};
      no_ovl = (s_c == 32'd0) || (m_c[0] >= {1'b0, s_c}) || (m_c[1] >= {1'b0, s_c})
            || (m_c[2] >= {1'b0, s_c});
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = s_ff;
      mul_b = s_ff;
      if (state_ff == S_PMUL) begin
         mul_a = mag_ff[comp_ff];
         mul_b = gap_ff;
      end else if (sq_cnt_ff < 3'd3) begin
         mul_a = mag_ff[sq_cnt_ff[1:0]];
         mul_b = mag_ff[sq_cnt_ff[1:0]];
      end
   end
   assign mul_p = mul_a * mul_b;

   always_comb begin
      rt_rem = {rem_ff[32:0], rad_ff[63:62]};
      rt_trial = {1'b0, root_ff, 2'b01};
      dv_t = {drem_ff, prod_ff[63]};
      ap_off = neg_ff[comp_ff] ? (34'd0 - {2'b00, prod_ff[31:0]})
                               : {2'b00, prod_ff[31:0]};
      ap_sum = {{2{st_pos_ff[comp_ff][31]}}, st_pos_ff[comp_ff]} + ap_off;
   end

   always_comb begin
      wr_en = 1'b0;
      wr_addr = count_ff[IW-1:0];
      wr_entry.pos_x = sat34({{2{req_pos_x[31]}}, req_pos_x} + {{2{req_vel_x[31]}}, req_vel_x});
      wr_entry.pos_y = sat34({{2{req_pos_y[31]}}, req_pos_y} + {{2{req_vel_y[31]}}, req_vel_y});
      wr_entry.pos_z = sat34({{2{req_pos_z[31]}}, req_pos_z} + {{2{req_vel_z[31]}}, req_vel_z});
      wr_entry.radius = req_radius;
      wr_entry.prio = req_priority_req;
      if (state_ff == S_WR) begin
         wr_en = 1'b1;
         wr_addr = mv_idx_ff;
         wr_entry.pos_x = new_ff[0];
         wr_entry.pos_y = new_ff[1];
         wr_entry.pos_z = new_ff[2];
         wr_entry.radius = mv_rad_ff;
         wr_entry.prio = mv_pri_ff;
      end else if (req_acc && count_ff < CW'(sopr_pkg::MAX_OBJECTS)) begin
         wr_en = 1'b1;
      end
   end

   always_comb begin
      unique case (state_ff)
         S_RDI:   rd_addr = i_ff;
         S_RDJ:   rd_addr = j_ff;
         default: rd_addr = k_ff;
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      i_in = i_ff;
      j_in = j_ff;
      k_in = k_ff;
      pass_in = pass_ff;
      limit_in = limit_ff;
      hit_in = hit_ff;
      a_in = a_ff;
      b_in = b_ff;
      mag_in = mag_ff;
      neg_in = neg_ff;
      s_in = s_ff;
      gap_in = gap_ff;
      sq_cnt_in = sq_cnt_ff;
      prod_in = prod_ff;
      s2_in = s2_ff;
      acc_in = acc_ff;
      st_idx_in = st_idx_ff;
      mv_idx_in = mv_idx_ff;
      st_pos_in = st_pos_ff;
      new_in = new_ff;
      mv_rad_in = mv_rad_ff;
      mv_pri_in = mv_pri_ff;
      rad_in = rad_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      drem_in = drem_ff;
      iter_in = iter_ff;
      comp_in = comp_ff;
      o_idx_in = o_idx_ff;
      o_x_in = o_x_ff;
      o_y_in = o_y_ff;
      o_z_in = o_z_ff;
      o_hit_in = o_hit_ff;
      o_par_in = o_par_ff;
      o_last_in = o_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (count_ff == '0) hit_in = '0;
               if (count_ff < CW'(sopr_pkg::MAX_OBJECTS)) count_in = count_ff + 1'b1;
               if (req_last_object) begin
                  i_in = '0;
                  j_in = '0;
                  pass_in = '0;
                  limit_in = 1'b0;
                  state_in = S_PAIR;
               end
            end
         end
         S_PAIR: begin
            if (i_ff == j_ff) begin
               i_in = adv_i;
               j_in = adv_j;
               if (adv_done) begin
                  k_in = '0;
                  state_in = S_ORD;
               end
            end else begin
               state_in = S_RDI;
            end
         end
         S_RDI: state_in = S_RDJ;
         S_RDJ: begin
            a_in = rd_entry;
            state_in = S_CAPJ;
         end
         S_CAPJ: begin
            b_in = rd_entry;
            state_in = S_OVL;
         end
         S_OVL: begin
            for (int c = 0; c < 3; c++) begin
               mag_in[c] = m_c[c][31:0];
               neg_in[c] = d_c[c][32];
            end
            s_in = s_c;
            sq_cnt_in = '0;
            acc_in = '0;
            if (no_ovl) begin
               i_in = adv_i;
               j_in = adv_j;
               if (adv_done) begin
                  k_in = '0;
                  state_in = S_ORD;
               end else begin
                  state_in = S_PAIR;
               end
            end else begin
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            if (sq_cnt_ff < 3'd4) prod_in = mul_p;
            if (sq_cnt_ff >= 3'd1 && sq_cnt_ff <= 3'd3) acc_in = acc_ff + {2'b00, prod_ff};
            if (sq_cnt_ff == 3'd4) begin
               s2_in = prod_ff;
               state_in = S_CMP;
            end
            sq_cnt_in = sq_cnt_ff + 1'b1;
         end
         S_CMP: begin
            if (acc_ff < {2'b00, s2_ff}) begin
               // lower priority moves; on a tie the inner object moves
               if (a_ff.prio < b_ff.prio) begin
                  st_idx_in = j_ff;
                  mv_idx_in = i_ff;
                  st_pos_in[0] = b_ff.pos_x;
                  st_pos_in[1] = b_ff.pos_y;
                  st_pos_in[2] = b_ff.pos_z;
                  mv_rad_in = a_ff.radius;
                  mv_pri_in = a_ff.prio;
                  neg_in = ~neg_ff;
               end else begin
                  st_idx_in = i_ff;
                  mv_idx_in = j_ff;
                  st_pos_in[0] = a_ff.pos_x;
                  st_pos_in[1] = a_ff.pos_y;
                  st_pos_in[2] = a_ff.pos_z;
                  mv_rad_in = b_ff.radius;
                  mv_pri_in = b_ff.prio;
               end
               gap_in = s_ff + 32'd1;
               rad_in = acc_ff[63:0];
               rem_in = '0;
               root_in = '0;
               iter_in = '0;
               state_in = S_SQRT;
            end else begin
               i_in = adv_i;
               j_in = adv_j;
               if (adv_done) begin
                  k_in = '0;
                  state_in = S_ORD;
               end else begin
                  state_in = S_PAIR;
               end
            end
         end
         S_SQRT: begin
            // two radicand bits per step
            if (rt_rem >= rt_trial) begin
               rem_in = rt_rem - rt_trial;
               root_in = {root_ff[30:0], 1'b1};
            end else begin
               rem_in = rt_rem;
               root_in = {root_ff[30:0], 1'b0};
            end
            rad_in = {rad_ff[61:0], 2'b00};
            iter_in = iter_ff + 1'b1;
            if (iter_ff == 6'd31) begin
               comp_in = '0;
               if (root_in == 32'd0) begin
                  // coincident centres: push along +x
                  new_in[0] = sat34({{2{st_pos_ff[0][31]}}, st_pos_ff[0]} + {2'b00, gap_ff});
                  new_in[1] = st_pos_ff[1];
                  new_in[2] = st_pos_ff[2];
                  state_in = S_WR;
               end else begin
                  state_in = S_PMUL;
               end
            end
         end
         S_PMUL: begin
            prod_in = mul_p;
            drem_in = '0;
            iter_in = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            // restoring divide of |d| * gap by len
            if (dv_t >= {1'b0, root_ff}) begin
               drem_in = 32'(dv_t - {1'b0, root_ff});
               prod_in = {prod_ff[62:0], 1'b1};
            end else begin
               drem_in = dv_t[31:0];
               prod_in = {prod_ff[62:0], 1'b0};
            end
            iter_in = iter_ff + 1'b1;
            if (iter_ff == 6'd63) state_in = S_APPLY;
         end
         S_APPLY: begin
            new_in[comp_ff] = sat34(ap_sum);
            comp_in = comp_ff + 1'b1;
            if (comp_ff == 2'd2) state_in = S_WR;
            else state_in = S_PMUL;
         end
         S_WR: begin
            hit_in[st_idx_ff] = 1'b1;
            hit_in[mv_idx_ff] = 1'b1;
            i_in = '0;
            j_in = '0;
            if (pass_ff >= max_passes_ff) begin
               limit_in = 1'b1;
               k_in = '0;
               state_in = S_ORD;
            end else begin
               pass_in = pass_ff + 1'b1;
               state_in = S_PAIR;
            end
         end
         S_ORD: state_in = S_OLD;
         S_OLD: begin
            o_idx_in = 5'(k_ff);
            o_x_in = rd_entry.pos_x;
            o_y_in = rd_entry.pos_y;
            o_z_in = rd_entry.pos_z;
            o_hit_in = hit_ff[k_ff];
            o_par_in = hit_ff[k_ff] ? 5'(partner_ff[k_ff]) : 5'd0;
            o_last_in = ({1'b0, k_ff} == count_ff - 1'b1);
            state_in = S_OSEND;
         end
         S_OSEND: begin
            if (!rsp_stall) begin
               if (o_last_ff) begin
                  count_in = '0;
                  state_in = S_IDLE;
               end else begin
                  k_in = k_ff + 1'b1;
                  state_in = S_ORD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pass_ff <= '0;
         limit_ff <= 1'b0;
         hit_ff <= '0;
         max_passes_ff <= sopr_pkg::MAX_PASSES_RESET;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pass_ff <= pass_in;
         limit_ff <= limit_in;
         hit_ff <= hit_in;
         if (csr_write_enable) max_passes_ff <= csr_write_data;
      end
   end

   // first partner is only recorded the first time an object is hit
   always_ff @(posedge clock) begin
      if (state_ff == S_WR) begin
         if (!hit_ff[st_idx_ff]) partner_ff[st_idx_ff] <= mv_idx_ff;
         if (!hit_ff[mv_idx_ff]) partner_ff[mv_idx_ff] <= st_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;
      j_ff <= j_in;
      k_ff <= k_in;
      a_ff <= a_in;
      b_ff <= b_in;
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      s_ff <= s_in;
      gap_ff <= gap_in;
      sq_cnt_ff <= sq_cnt_in;
      prod_ff <= prod_in;
      s2_ff <= s2_in;
      acc_ff <= acc_in;
      st_idx_ff <= st_idx_in;
      mv_idx_ff <= mv_idx_in;
      st_pos_ff <= st_pos_in;
      new_ff <= new_in;
      mv_rad_ff <= mv_rad_in;
      mv_pri_ff <= mv_pri_in;
      rad_ff <= rad_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
      drem_ff <= drem_in;
      iter_ff <= iter_in;
      comp_ff <= comp_in;
      o_idx_ff <= o_idx_in;
      o_x_ff <= o_x_in;
      o_y_ff <= o_y_in;
      o_z_ff <= o_z_in;
      o_hit_ff <= o_hit_in;
      o_par_ff <= o_par_in;
      o_last_ff <= o_last_in;
   end

   assign rsp_object_index = o_idx_ff;
   assign rsp_final_x = o_x_ff;
   assign rsp_final_y = o_y_ff;
   assign rsp_final_z = o_z_ff;
   assign rsp_collided = o_hit_ff;
   assign rsp_partner_index = o_par_ff;
   assign rsp_limit_reached = limit_ff;
   assign rsp_last_result = o_last_ff;

   // the push-out quotient never exceeds the gap
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPLY) |-> (prod_ff[63:32] == 32'd0 && prod_ff[31:0] <= gap_ff))
      else $error("push-out quotient exceeds gap");

   // reported index stays within the loaded objects
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_object_index} < count_ff))
      else $error("reported index beyond object count");

   // partner is zero when no hit was recorded
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_collided) |-> (rsp_partner_index == 5'd0))
      else $error("partner without hit");

   // the final word returns the block to loading
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_result) |=> (!req_stall && count_ff == '0))
      else $error("block not idle after last word");

endmodule
